### rtl/core/cdt_pkg.sv
package cdt_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ENCRYPTION_ON = 3'd0;
  localparam logic [2:0] REG_SKIP_COUNT    = 3'd1;
  localparam logic [2:0] REG_KEY_SEED      = 3'd2;
  localparam logic [2:0] REG_MULT_C1       = 3'd3;
  localparam logic [2:0] REG_ADD_C2        = 3'd4;
  localparam logic [2:0] REG_ESCAPE_CODE   = 3'd5;
  localparam logic [2:0] REG_SHORTINT_CODE = 3'd6;

  localparam int unsigned PADDR_W = 5;

  // Register reset values.
  localparam logic        RST_ENCRYPTION_ON = 1'b1;
  localparam logic [7:0]  RST_SKIP_COUNT    = 8'd4;
  localparam logic [15:0] RST_KEY_SEED      = 16'd4330;
  localparam logic [15:0] RST_MULT_C1       = 16'd52845;
  localparam logic [15:0] RST_ADD_C2        = 16'd22719;
  localparam logic [4:0]  RST_ESCAPE_CODE   = 5'd12;
  localparam logic [4:0]  RST_SHORTINT_CODE = 5'd28;

  // Result kinds.
  localparam logic [1:0] KIND_NUMBER  = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_ESCAPE  = 2'd2;
  localparam logic [1:0] KIND_RUNOFF  = 2'd3;

  // Byte ranges of the tokenizer.
  localparam logic [7:0] SMALL_LO    = 8'd32;
  localparam logic [7:0] SMALL_HI    = 8'd246;
  localparam logic [7:0] SMALL_BIAS  = 8'd139;
  localparam logic [7:0] POS_LO      = 8'd247;
  localparam logic [7:0] POS_HI      = 8'd250;
  localparam logic [7:0] NEG_LO      = 8'd251;
  localparam logic [7:0] NEG_HI      = 8'd254;
  localparam logic [7:0] LONG_LEAD   = 8'd255;
  localparam logic [7:0] MEDIUM_BIAS = 8'd108;

  // Current configuration values.
  typedef struct packed {
    logic        encryption_on;
    logic [7:0]  skip_count;
    logic [15:0] key_seed;
    logic [15:0] mult_c1;
    logic [15:0] add_c2;
    logic [4:0]  escape_code;
    logic [4:0]  shortint_code;
  } cfg_t;

  // Write strobes that reload the running decryption state.
  typedef struct packed {
    logic        key_load;
    logic        skip_load;
    logic [15:0] wval;
  } cfg_wr_t;

  // One decrypted byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0] plain;
    logic       use_byte;
    logic       last;
  } q_ent_t;

endpackage

### rtl/core/cdt_in_if.sv
interface cdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/cdt_out_if.sv
interface cdt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         token_kind;
  logic signed [31:0] token_value;
  logic               last_result;

  modport source (output valid, output token_kind, output token_value,
                  output last_result, input ready);
  modport sink (input valid, input token_kind, input token_value,
                input last_result, output ready);
endinterface

### rtl/core/cdt_regs.sv
module cdt_regs
  import cdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg,
  output cfg_wr_t            cfg_wr
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign cfg    = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt          = cfg_r;
    cfg_wr.key_load  = 1'b0;
    cfg_wr.skip_load = 1'b0;
    cfg_wr.wval      = pwdata[15:0];
    if (wr_en) begin
      unique case (idx)
        REG_ENCRYPTION_ON: cfg_nxt.encryption_on = pwdata[0];
        REG_SKIP_COUNT: begin
          cfg_nxt.skip_count = pwdata[7:0];
          cfg_wr.skip_load   = 1'b1;
        end
        REG_KEY_SEED: begin
          cfg_nxt.key_seed = pwdata[15:0];
          cfg_wr.key_load  = 1'b1;
        end
        REG_MULT_C1:       cfg_nxt.mult_c1       = pwdata[15:0];
        REG_ADD_C2:        cfg_nxt.add_c2        = pwdata[15:0];
        REG_ESCAPE_CODE:   cfg_nxt.escape_code   = pwdata[4:0];
        REG_SHORTINT_CODE: cfg_nxt.shortint_code = pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_ENCRYPTION_ON: prdata = {31'd0, cfg_r.encryption_on};
      REG_SKIP_COUNT:    prdata = {24'd0, cfg_r.skip_count};
      REG_KEY_SEED:      prdata = {16'd0, cfg_r.key_seed};
      REG_MULT_C1:       prdata = {16'd0, cfg_r.mult_c1};
      REG_ADD_C2:        prdata = {16'd0, cfg_r.add_c2};
      REG_ESCAPE_CODE:   prdata = {27'd0, cfg_r.escape_code};
      REG_SHORTINT_CODE: prdata = {27'd0, cfg_r.shortint_code};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.encryption_on <= RST_ENCRYPTION_ON;
      cfg_r.skip_count    <= RST_SKIP_COUNT;
      cfg_r.key_seed      <= RST_KEY_SEED;
      cfg_r.mult_c1       <= RST_MULT_C1;
      cfg_r.add_c2        <= RST_ADD_C2;
      cfg_r.escape_code   <= RST_ESCAPE_CODE;
      cfg_r.shortint_code <= RST_SHORTINT_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/cdt_front.sv
module cdt_front
  import cdt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  cdt_in_if.sink  in_if,
  input  cfg_t    cfg,
  input  cfg_wr_t cfg_wr,
  input  logic    q_full,
  output logic    q_push,
  output q_ent_t  q_ent
);

  logic [15:0] key_r;
  logic [15:0] key_nxt;
  logic [7:0]  skip_r;
  logic [7:0]  skip_nxt;
  logic [15:0] key_sum;
  logic [31:0] key_prod;
  logic        skipping;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  // Decrypt the byte and classify it as skipped or used.
  assign skipping       = cfg.encryption_on && (skip_r != 8'd0);
  assign key_sum        = key_r + {8'd0, in_if.data_byte};
  assign key_prod       = key_sum * cfg.mult_c1;
  assign q_ent.plain    = cfg.encryption_on ? (in_if.data_byte ^ key_r[15:8])
                                            : in_if.data_byte;
  assign q_ent.use_byte = !skipping;
  assign q_ent.last     = in_if.last_byte;

  // Key and skip counter; both restart after the last byte.
  always_comb begin
    key_nxt  = key_r;
    skip_nxt = skip_r;
    if (cfg_wr.key_load) begin
      key_nxt = cfg_wr.wval;
    end
    if (cfg_wr.skip_load) begin
      skip_nxt = cfg_wr.wval[7:0];
    end
    if (q_push) begin
      if (cfg.encryption_on) begin
        key_nxt = key_prod[15:0] + cfg.add_c2;
        if (skipping) begin
          skip_nxt = skip_r - 8'd1;
        end
      end
      if (in_if.last_byte) begin
        key_nxt  = cfg.key_seed;
        skip_nxt = cfg.skip_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= RST_KEY_SEED;
      skip_r <= RST_SKIP_COUNT;
    end else begin
      key_r  <= key_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

### rtl/core/cdt_fifo.sv
module cdt_fifo
  import cdt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  q_ent_t wdata,
  input  logic   pop,
  output q_ent_t rdata,
  output logic   not_empty,
  output logic   full
);

  q_ent_t     ent_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign rdata     = ent_r[rptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

### rtl/core/cdt_back.sv
module cdt_back
  import cdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_ent_t    q_ent,
  output logic      q_pop,
  cdt_out_if.source out_if
);

  logic [7:0]  lead_r;
  logic [7:0]  lead_nxt;
  logic [31:0] gath_r;
  logic [31:0] gath_nxt;
  logic [2:0]  need_r;
  logic [2:0]  need_nxt;
  logic        pend_r;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_value_r;
  logic        out_last_r;

  logic        out_free;
  logic        tok_hit;
  logic [1:0]  tok_kind;
  logic [31:0] tok_value;
  logic [7:0]  b;
  logic [31:0] gath_sh;
  logic [2:0]  need_dec;
  logic [7:0]  lead_off;
  logic [31:0] mid_num;

  assign out_free = !out_valid_r || out_if.ready;
  assign q_pop    = q_valid && out_free && !pend_r;

  assign b        = q_ent.plain;
  assign gath_sh  = {gath_r[23:0], b};
  assign need_dec = need_r - 3'd1;
  assign lead_off = (lead_r >= NEG_LO) ? (lead_r - NEG_LO) : (lead_r - POS_LO);
  assign mid_num  = {22'd0, lead_off[1:0], 8'd0} + {24'd0, MEDIUM_BIAS} + {24'd0, b};

  // Tokenizer step for one used byte.
  always_comb begin
    tok_hit   = 1'b0;
    tok_kind  = KIND_NUMBER;
    tok_value = 32'd0;
    lead_nxt  = lead_r;
    gath_nxt  = gath_r;
    need_nxt  = need_r;
    if (q_ent.use_byte) begin
      if (need_r == 3'd0) begin
        if (b >= SMALL_LO && b <= SMALL_HI) begin
          tok_hit   = 1'b1;
          tok_value = {24'd0, b} - {24'd0, SMALL_BIAS};
        end else begin
          lead_nxt = b;
          gath_nxt = 32'd0;
          if (b == {3'd0, cfg.shortint_code}) begin
            need_nxt = 3'd2;
          end else if (b < SMALL_LO) begin
            if (b == {3'd0, cfg.escape_code}) begin
              need_nxt = 3'd1;
            end else begin
              tok_hit   = 1'b1;
              tok_kind  = KIND_COMMAND;
              tok_value = {24'd0, b};
            end
          end else begin
            need_nxt = (b == LONG_LEAD) ? 3'd4 : 3'd1;
          end
        end
      end else begin
        gath_nxt = gath_sh;
        need_nxt = need_dec;
        if (need_dec == 3'd0) begin
          tok_hit  = 1'b1;
          lead_nxt = 8'd0;
          gath_nxt = 32'd0;
          if (lead_r < SMALL_LO) begin
            if (lead_r == {3'd0, cfg.shortint_code}) begin
              tok_value = {{16{gath_sh[15]}}, gath_sh[15:0]};
            end else begin
              tok_kind  = KIND_ESCAPE;
              tok_value = {24'd0, b};
            end
          end else if (lead_r >= POS_LO && lead_r <= POS_HI) begin
            tok_value = mid_num;
          end else if (lead_r >= NEG_LO && lead_r <= NEG_HI) begin
            tok_value = 32'd0 - mid_num;
          end else begin
            tok_value = gath_sh;
          end
        end
      end
    end
    // The last byte drops any unfinished token.
    if (q_ent.last) begin
      lead_nxt = 8'd0;
      gath_nxt = 32'd0;
      need_nxt = 3'd0;
    end
  end

  // Tokenizer state advances on each popped byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 8'd0;
      gath_r <= 32'd0;
      need_r <= 3'd0;
    end else if (q_pop) begin
      lead_r <= lead_nxt;
      gath_r <= gath_nxt;
      need_r <= need_nxt;
    end
  end

  // Output register; a runoff behind a token waits in the pending flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (q_pop) begin
        out_valid_r <= tok_hit || q_ent.last;
        pend_r      <= tok_hit && q_ent.last;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_r || (q_pop && !tok_hit)) begin
        out_kind_r  <= KIND_RUNOFF;
        out_value_r <= 32'd0;
        out_last_r  <= 1'b1;
      end else begin
        out_kind_r  <= tok_kind;
        out_value_r <= tok_value;
        out_last_r  <= 1'b0;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.token_kind  = out_kind_r;
  assign out_if.token_value = $signed(out_value_r);
  assign out_if.last_result = out_last_r;

endmodule

### rtl/core/charstring_decrypt_tokenize.sv
// An accepted byte is written into the queue, from which the tokenizer pops it; its result
// is then held in the output register until the receiver takes it.
// Throughput: one byte per cycle while the receiver takes results; a byte that both
// completes a token and ends the charstring gives the token and then the runoff.
// The key update is one 16x16 multiply-add per byte in the front stage.
// Reset (rst_n, synchronous, active low) restores the register defaults, reloads
// the key and skip counter, and empties the queue and the output stage.
module charstring_decrypt_tokenize
  import cdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  cdt_in_if.sink             in_if,
  cdt_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t    cfg;
  cfg_wr_t cfg_wr;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_valid;
  q_ent_t  q_wdata;
  q_ent_t  q_rdata;

  // Configuration registers.
  cdt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // Decryption and skipping.
  cdt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg    (cfg),
    .cfg_wr (cfg_wr),
    .q_full (q_full),
    .q_push (q_push),
    .q_ent  (q_wdata)
  );

  // Queue between the two halves.
  cdt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // Tokenizer and result output.
  cdt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ent   (q_rdata),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

### bench/tb_charstring_decrypt_tokenize.sv
`timescale 1ns / 1ps

module tb_charstring_decrypt_tokenize;
  import cdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BYTES  = 700;
  // Index just past the register list; a write there must change nothing.
  localparam logic [2:0]  REG_UNUSED  = 3'd7;

  // One token as it leaves the block.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               last;
  } token_t;

  localparam token_t RUNOFF_TOKEN = '{kind: KIND_RUNOFF, value: 32'sd0, last: 1'b1};

  // One line of the directed stimulus: a register write or one plain byte.
  typedef struct packed {
    logic               is_cfg;
    logic [2:0]         reg_idx;
    logic [15:0]        wval;
    logic [7:0]         plain;
    logic               last;
    logic               typed;
    logic               has_tok;
    logic [1:0]         kind;
    logic signed [31:0] value;
  } row_t;

  // One byte of a generated charstring; raw bytes go out without encryption.
  typedef struct packed {
    logic [7:0] val;
    logic       raw;
  } cs_byte_t;

  logic clk;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  cdt_in_if  byte_ch ();
  cdt_out_if tok_ch ();

  charstring_decrypt_tokenize uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (byte_ch),
    .out_if  (tok_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the configuration registers.
  logic        reg_enc;
  logic [7:0]  reg_skip;
  logic [15:0] reg_seed;
  logic [15:0] reg_mult;
  logic [15:0] reg_add;
  logic [4:0]  reg_esc;
  logic [4:0]  reg_short;

  // Mirror of the decryption and tokenizer state.
  logic [15:0] key_q;
  logic [7:0]  skip_q;
  logic [7:0]  lead_q;
  logic [31:0] gath_q;
  logic [2:0]  need_q;

  token_t   pending_tokens[$];
  row_t     dir_rows[$];
  cs_byte_t str_q[$];

  int burst_left;
  int stall_mode;
  int stall_ctr;
  int n_bytes;
  int n_used;
  int n_results;
  int n_strings;
  int n_writes;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run guard.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
    $display("tb_charstring_decrypt_tokenize NOT OK");
    $finish;
  end

  // Start a new charstring: key, skip counter and token state reload.
  function automatic void restart_string();
    key_q  = reg_seed;
    skip_q = reg_skip;
    lead_q = '0;
    gath_q = '0;
    need_q = '0;
  endfunction

  // Predict what one raw byte produces and queue the resulting tokens.
  task automatic decode_byte(input logic [7:0] cipher, input logic last, input bit record);
    logic [7:0] plain;
    bit         use_it;
    bit         done;
    token_t     t;
    plain  = cipher;
    use_it = 1'b1;
    done   = 1'b0;
    t      = '0;
    if (reg_enc) begin
      plain = cipher ^ key_q[15:8];
      key_q = ({8'h00, cipher} + key_q) * reg_mult + reg_add;
      if (skip_q != 8'd0) begin
        skip_q = skip_q - 8'd1;
        use_it = 1'b0;
      end
    end
    if (use_it) begin
      n_used++;
      if (need_q == 3'd0) begin
        if (plain >= SMALL_LO && plain <= SMALL_HI) begin
          t.kind  = KIND_NUMBER;
          t.value = int'(plain) - int'(SMALL_BIAS);
          done    = 1'b1;
        end else begin
          lead_q = plain;
          gath_q = '0;
          // The 16-bit number code wins over the escape code.
          if (plain == {3'b000, reg_short}) begin
            need_q = 3'd2;
          end else if (plain < SMALL_LO) begin
            if (plain == {3'b000, reg_esc}) begin
              need_q = 3'd1;
            end else begin
              t.kind  = KIND_COMMAND;
              t.value = int'(plain);
              done    = 1'b1;
            end
          end else begin
            need_q = (plain == LONG_LEAD) ? 3'd4 : 3'd1;
          end
        end
      end else begin
        gath_q = {gath_q[23:0], plain};
        need_q = need_q - 3'd1;
        if (need_q == 3'd0) begin
          done   = 1'b1;
          t.kind = KIND_NUMBER;
          // Low lead bytes are judged against the codes in force now.
          if (lead_q < SMALL_LO) begin
            if (lead_q == {3'b000, reg_short}) begin
              t.value = {{16{gath_q[15]}}, gath_q[15:0]};
            end else begin
              t.kind  = KIND_ESCAPE;
              t.value = int'(plain);
            end
          end else if (lead_q >= POS_LO && lead_q <= POS_HI) begin
            t.value = (int'(lead_q) - int'(POS_LO)) * 256 + int'(MEDIUM_BIAS) + int'(plain);
          end else if (lead_q >= NEG_LO && lead_q <= NEG_HI) begin
            t.value = -((int'(lead_q) - int'(NEG_LO)) * 256 + int'(MEDIUM_BIAS) + int'(plain));
          end else begin
            t.value = gath_q;
          end
          lead_q = '0;
          gath_q = '0;
        end
      end
    end
    if (record && done) pending_tokens.push_back(t);
    if (last) begin
      if (record) pending_tokens.push_back(RUNOFF_TOKEN);
      restart_string();
    end
  endtask

  // Send one byte as a request, in bursts with random gaps, then predict it.
  task automatic feed_byte(input logic [7:0] val, input bit raw, input logic last,
                           input bit record);
    logic [7:0] cipher;
    if (burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    cipher = (raw || !reg_enc) ? val : (val ^ key_q[15:8]);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= cipher;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    n_bytes++;
    decode_byte(cipher, last, record);
  endtask

  // Let every expected result arrive, then write one register over APB.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
    case (idx)
      REG_ENCRYPTION_ON: reg_enc = val[0];
      REG_SKIP_COUNT: begin
        reg_skip = val[7:0];
        skip_q   = val[7:0];
      end
      REG_KEY_SEED: begin
        reg_seed = val;
        key_q    = val;
      end
      REG_MULT_C1:       reg_mult  = val;
      REG_ADD_C2:        reg_add   = val;
      REG_ESCAPE_CODE:   reg_esc   = val[4:0];
      REG_SHORTINT_CODE: reg_short = val[4:0];
      default: ;
    endcase
  endtask

  function automatic void add_write(input logic [2:0] idx, input logic [15:0] val);
    row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.wval    = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] plain, input logic last);
    row_t r;
    r = '0;
    r.plain = plain;
    r.last  = last;
    dir_rows.push_back(r);
  endfunction

  // A byte whose outcome is written out by hand; a runoff follows when last is set.
  function automatic void add_known(input logic [7:0] plain, input logic last,
                                    input logic has_tok, input logic [1:0] kind,
                                    input int value);
    row_t r;
    r = '0;
    r.plain   = plain;
    r.last    = last;
    r.typed   = 1'b1;
    r.has_tok = has_tok;
    r.kind    = kind;
    r.value   = value;
    dir_rows.push_back(r);
  endfunction

  // Queue one well-formed token of random type, or now and then a noise byte.
  function automatic void gen_token();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: str_q.push_back({8'($urandom_range(SMALL_LO, SMALL_HI)), 1'b0});
      3: str_q.push_back({8'($urandom_range(0, 31)), 1'b0});
      4: begin
        str_q.push_back({3'b000, reg_esc, 1'b0});
        str_q.push_back({8'($urandom), 1'b0});
      end
      5: begin
        str_q.push_back({3'b000, reg_short, 1'b0});
        repeat (2) str_q.push_back({8'($urandom), 1'b0});
      end
      6: begin
        str_q.push_back({8'($urandom_range(POS_LO, POS_HI)), 1'b0});
        str_q.push_back({8'($urandom), 1'b0});
      end
      7: begin
        str_q.push_back({8'($urandom_range(NEG_LO, NEG_HI)), 1'b0});
        str_q.push_back({8'($urandom), 1'b0});
      end
      8: begin
        str_q.push_back({LONG_LEAD, 1'b0});
        repeat (4) str_q.push_back({8'($urandom), 1'b0});
      end
      default: str_q.push_back({8'($urandom), 1'b1});
    endcase
  endfunction

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin : result_check
    token_t want;
    if (rst_n && tok_ch.valid && tok_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got kind %0d value %0d last %0d", $time,
                 tok_ch.token_kind, tok_ch.token_value, tok_ch.last_result);
      end else begin
        want = pending_tokens.pop_front();
        n_results++;
        if (tok_ch.token_kind !== want.kind || tok_ch.token_value !== want.value ||
            tok_ch.last_result !== want.last) begin
          mismatches++;
          $display("%0t: expected kind %0d value %0d last %0d, got kind %0d value %0d last %0d",
                   $time, want.kind, want.value, want.last, tok_ch.token_kind,
                   tok_ch.token_value, tok_ch.last_result);
        end
      end
    end
    // Stretches of full speed, random stalls and heavy stalls.
    if (stall_ctr == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_ctr  = $urandom_range(20, 80);
    end else begin
      stall_ctr = stall_ctr - 1;
    end
    case (stall_mode)
      0:       tok_ch.ready <= 1'b1;
      1:       tok_ch.ready <= 1'($urandom_range(0, 1));
      default: tok_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    row_t        r;
    logic [2:0]  idx;
    logic [15:0] val;
    int          ext;
    int          ntok;
    int          guard;

    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    burst_left = 0;
    stall_mode = 0;
    stall_ctr  = 0;
    n_bytes    = 0;
    n_used     = 0;
    n_results  = 0;
    n_strings  = 0;
    n_writes   = 0;
    mismatches = 0;

    // Directed part: defaults after reset, with decryption and lead skipping.
    repeat (4) add_byte(8'h00, 1'b0);
    add_byte(8'd139, 1'b1);
    // Last byte while skipping gives only the runoff.
    add_byte(8'hA5, 1'b1);
    // Out-of-range index first; it must not touch any register.
    add_write(REG_UNUSED, 16'h0001);
    add_write(REG_ENCRYPTION_ON, 16'h0000);
    add_known(8'd32, 1'b0, 1'b1, KIND_NUMBER, -107);
    add_known(8'd0, 1'b0, 1'b1, KIND_COMMAND, 0);
    add_known(8'd12, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'd255, 1'b0, 1'b1, KIND_ESCAPE, 255);
    add_known(8'd28, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'h80, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'h00, 1'b0, 1'b1, KIND_NUMBER, -32768);
    add_known(8'd250, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'd255, 1'b0, 1'b1, KIND_NUMBER, 1131);
    add_known(8'd255, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'h7F, 1'b0, 1'b0, KIND_NUMBER, 0);
    repeat (2) add_known(8'hFF, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'hFF, 1'b0, 1'b1, KIND_NUMBER, 2147483647);
    // A token completed by the last byte comes before the runoff.
    add_known(8'd254, 1'b0, 1'b0, KIND_NUMBER, 0);
    add_known(8'd255, 1'b1, 1'b1, KIND_NUMBER, -1131);
    // An unfinished token at the last byte is dropped.
    add_known(8'd247, 1'b1, 1'b0, KIND_NUMBER, 0);
    // Equal codes: the byte starts a 16-bit number.
    add_write(REG_ESCAPE_CODE, 16'd28);
    add_byte(8'd28, 1'b0);
    add_byte(8'd1, 1'b0);
    add_byte(8'd2, 1'b1);
    // Codes changed inside a token, both ways.
    add_byte(8'd28, 1'b0);
    add_byte(8'd0, 1'b0);
    add_write(REG_SHORTINT_CODE, 16'd5);
    add_known(8'd7, 1'b1, 1'b1, KIND_ESCAPE, 7);
    add_write(REG_ESCAPE_CODE, 16'd12);
    add_byte(8'd12, 1'b0);
    add_write(REG_SHORTINT_CODE, 16'd12);
    add_known(8'd9, 1'b1, 1'b1, KIND_NUMBER, 9);
    // Every register written for the random part, most at their extremes.
    add_write(REG_ENCRYPTION_ON, 16'h0001);
    add_write(REG_SKIP_COUNT, 16'd2);
    add_write(REG_KEY_SEED, 16'h0000);
    add_write(REG_MULT_C1, 16'hFFFF);
    add_write(REG_ADD_C2, 16'hFFFF);
    add_write(REG_ESCAPE_CODE, 16'd31);
    add_write(REG_SHORTINT_CODE, 16'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    reg_enc   = RST_ENCRYPTION_ON;
    reg_skip  = RST_SKIP_COUNT;
    reg_seed  = RST_KEY_SEED;
    reg_mult  = RST_MULT_C1;
    reg_add   = RST_ADD_C2;
    reg_esc   = RST_ESCAPE_CODE;
    reg_short = RST_SHORTINT_CODE;
    restart_string();

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_cfg) begin
        write_reg(r.reg_idx, r.wval);
      end else begin
        feed_byte(r.plain, 1'b0, r.last, !r.typed);
        if (r.typed) begin
          if (r.has_tok) pending_tokens.push_back('{kind: r.kind, value: r.value, last: 1'b0});
          if (r.last) pending_tokens.push_back(RUNOFF_TOKEN);
        end
      end
    end

    // Random part: charstrings of mostly well-formed tokens under changing settings.
    while (n_bytes < RAND_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          idx = 3'($urandom_range(0, 7));
          ext = $urandom_range(0, 3);
          case (idx)
            REG_ENCRYPTION_ON: val = 16'($urandom_range(0, 3) != 0);
            REG_SKIP_COUNT:
              val = (ext == 0) ? 16'd0 :
                    (ext == 1 && $urandom_range(0, 3) == 0) ? 16'd255 :
                    16'($urandom_range(1, 8));
            REG_ESCAPE_CODE, REG_SHORTINT_CODE:
              val = (ext == 0) ? 16'd0 : (ext == 1) ? 16'd31 : 16'($urandom_range(0, 31));
            default:
              val = (ext == 0) ? 16'h0000 : (ext == 1) ? 16'hFFFF : 16'($urandom);
          endcase
          write_reg(idx, val);
        end
      end
      str_q.delete();
      if (reg_enc) repeat (skip_q) str_q.push_back({8'($urandom), 1'b1});
      if ($urandom_range(0, 9) == 0) begin
        // Pure noise.
        repeat ($urandom_range(1, 12)) str_q.push_back({8'($urandom), 1'b1});
      end else begin
        ntok = $urandom_range(0, 8);
        repeat (ntok) gen_token();
        if ($urandom_range(0, 3) == 0) begin
          // Broken ending: the charstring stops inside a token.
          case ($urandom_range(0, 3))
            0: begin
              str_q.push_back({3'b000, reg_short, 1'b0});
              repeat ($urandom_range(0, 1)) str_q.push_back({8'($urandom), 1'b0});
            end
            1: str_q.push_back({3'b000, reg_esc, 1'b0});
            2: str_q.push_back({8'($urandom_range(POS_LO, NEG_HI)), 1'b0});
            default: begin
              str_q.push_back({LONG_LEAD, 1'b0});
              repeat ($urandom_range(0, 3)) str_q.push_back({8'($urandom), 1'b0});
            end
          endcase
        end
      end
      if (str_q.size() == 0) gen_token();
      foreach (str_q[j]) feed_byte(str_q[j].val, str_q[j].raw, j == str_q.size() - 1, 1'b1);
      n_strings++;
    end

    // Drain what is still in flight.
    byte_ch.valid <= 1'b0;
    guard = 0;
    while (pending_tokens.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, pending_tokens.size());
    end

    $display("Sent %0d bytes (%0d tokenized) in %0d random charstrings after the directed table,",
             n_bytes, n_used, n_strings);
    $display("with %0d register writes; %0d results checked, %0d mismatches.",
             n_writes, n_results, mismatches);
    if (mismatches == 0) begin
      $display("tb_charstring_decrypt_tokenize OK");
    end else begin
      $display("tb_charstring_decrypt_tokenize NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cdt_pkg.sv
rtl/core/cdt_in_if.sv
rtl/core/cdt_out_if.sv
rtl/core/cdt_regs.sv
rtl/core/cdt_front.sv
rtl/core/cdt_fifo.sv
rtl/core/cdt_back.sv
rtl/core/charstring_decrypt_tokenize.sv
bench/tb_charstring_decrypt_tokenize.sv
